>>> rtl/pvs_pkg.sv
// ----------------------------------------------------------------------------
// pvs_pkg
// Types, constants and helpers shared by the pilot valve pressure stepper.
// ----------------------------------------------------------------------------
package pvs_pkg;

  localparam int SLOT_COUNT_DEF   = 4;
  localparam int WAIT_CAP_DEF     = 5;
  localparam int SAMPLE_COUNT_DEF = 3;

  localparam int REG_SLOTS        = 4;   // slot registers in the config space
  localparam int CARRIED_SAMPLES  = 3;   // samples carried by one input beat

  localparam int MINUTE_W = 11;
  localparam int MILLI_W  = 16;
  localparam int SLOT_W   = MINUTE_W + MILLI_W;
  localparam int CNT_W    = 8;
  localparam int LVL_W    = 3;
  localparam int PULSE_W  = 10;
  localparam int IDX_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int SUM_W    = MILLI_W + 2;
  localparam int ERR_W    = MILLI_W + 1;
  localparam int POS_W    = 3;

  // average = (sum * RECIP) >> RECIP_SH, exact for every sum below 2^SUM_W
  localparam int RECIP_SH = 19;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;

  localparam int PULSE_STEP = 100;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT3 = 3'd5;

  typedef enum logic [1:0] {
    VALVE_NONE  = 2'd0,
    VALVE_FILL  = 2'd1,
    VALVE_DRAIN = 2'd2
  } valve_t;

  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_PROG = 2'd1,
    WAIT_LONG = 2'd2
  } wait_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WALK,
    ST_ERR,
    ST_CMP,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic [MINUTE_W-1:0] minute_of_day;
    logic [MILLI_W-1:0]  sample_first;
    logic [MILLI_W-1:0]  sample_second;
    logic [MILLI_W-1:0]  sample_third;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         valve_action;
    logic [PULSE_W-1:0] pulse_ms;
    logic [1:0]         wait_kind;
    logic [LVL_W-1:0]   wait_units;
    logic [CNT_W-1:0]   fill_steps;
    logic [CNT_W-1:0]   drain_steps;
    logic [IDX_W-1:0]   active_slot;
    logic               no_slots;
    logic [MILLI_W-1:0] average_milli;
  } out_item_t;

  typedef struct packed {
    logic load;   // take the input beat
    logic mul;    // reciprocal multiply, clear the slot walk
    logic walk;   // visit one slot
    logic err;    // setpoint minus average
    logic cmp;    // magnitude, band check, pulse index
    logic upd;    // update state, load the output register
  } cmd_t;

  typedef struct packed {
    logic walk_last;
    logic out_free;
  } sts_t;

  function automatic logic [PULSE_W-1:0] pulse_of(input logic [POS_W-1:0] pos);
    logic [PULSE_W-1:0] w;
    case (pos)
      3'd0:    w = 10'd100;
      3'd1:    w = 10'd200;
      3'd2:    w = 10'd300;
      3'd3:    w = 10'd400;
      3'd4:    w = 10'd500;
      default: w = 10'd700;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/pvs_in_if.sv
// ----------------------------------------------------------------------------
// pvs_in_if
// Input channel: one control cycle per beat.
// ----------------------------------------------------------------------------
interface pvs_in_if;
  logic              valid;
  logic              ready;
  pvs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/pvs_out_if.sv
// ----------------------------------------------------------------------------
// pvs_out_if
// Result channel: one regulation decision per beat.
// ----------------------------------------------------------------------------
interface pvs_out_if;
  logic               valid;
  logic               ready;
  pvs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/pvs_cfg_if.sv
// ----------------------------------------------------------------------------
// pvs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pvs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pvs_pkg::CFG_IDX_W-1:0]    idx;
  logic [pvs_pkg::SLOT_W-1:0]       wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

>>> rtl/pilot_valve_pressure_stepper.sv
// ----------------------------------------------------------------------------
// pilot_valve_pressure_stepper
// Averages the pressure samples, picks the setpoint slot by time of day and
// decides a fill or drain pulse, step counts and the wait before next cycle.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        beat
//  in_ch    in   valid/ready      minute of day, three pressure samples
//  out_ch   out  valid/ready      valve action, pulse, wait, counters, slot
//  cfg_ch   in   valid/ready(=1)  register index, write data
//
//  A beat passes accept, multiply, the slot walk over min(SLOT_COUNT, 4) slots,
//  error, compare and update into the output register; the walk visits one slot a cycle.
//  The next beat is taken back in idle, not before the last one is through.
//  in_ch is ready again as soon as the result is loaded, while it still waits.
//  A stalled out_ch holds the sequencer in its update step.
//  rst_n is synchronous, active low; the config registers hold reset values after it.
// ----------------------------------------------------------------------------
module pilot_valve_pressure_stepper #(
  parameter int SLOT_COUNT   = pvs_pkg::SLOT_COUNT_DEF,
  parameter int WAIT_CAP     = pvs_pkg::WAIT_CAP_DEF,
  parameter int SAMPLE_COUNT = pvs_pkg::SAMPLE_COUNT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  pvs_in_if.sink     in_ch,
  pvs_out_if.source  out_ch,
  pvs_cfg_if.sink    cfg_ch
);
  import pvs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pvs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pvs_dp #(
    .SLOT_COUNT   (SLOT_COUNT),
    .WAIT_CAP     (WAIT_CAP),
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_ch.data),
    .cmd     (cmd),
    .sts     (sts),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch)
  );

endmodule

>>> rtl/pvs_ctrl.sv
// ----------------------------------------------------------------------------
// pvs_ctrl
// Sequencer: accept, multiply, walk the slots, error, compare, update.
// ----------------------------------------------------------------------------
module pvs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pvs_pkg::sts_t sts,
  output pvs_pkg::cmd_t cmd
);
  import pvs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WALK;
      ST_WALK: if (sts.walk_last) state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  if (sts.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL:  cmd.mul  = 1'b1;
      ST_WALK: cmd.walk = 1'b1;
      ST_ERR:  cmd.err  = 1'b1;
      ST_CMP:  cmd.cmp  = 1'b1;
      ST_UPD:  cmd.upd  = sts.out_free;
      default: cmd = '0;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && in_valid |=> state_r == ST_MUL)
    else $error("accepted beat did not start the sequence");

  a_walk_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK && sts.walk_last |=> state_r == ST_ERR)
    else $error("slot walk overran its last slot");

  a_upd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD && !sts.out_free |=> state_r == ST_UPD)
    else $error("left update while the output register was full");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.mul || cmd.walk || cmd.err || cmd.cmp || cmd.upd))
    else $error("ready raised while a beat is in progress");

endmodule

>>> rtl/pvs_dp.sv
// ----------------------------------------------------------------------------
// pvs_dp
// Datapath: config registers, averaging, slot walk, error, step counters,
// wait level and the output register.
// ----------------------------------------------------------------------------
module pvs_dp #(
  parameter int SLOT_COUNT   = pvs_pkg::SLOT_COUNT_DEF,
  parameter int WAIT_CAP     = pvs_pkg::WAIT_CAP_DEF,
  parameter int SAMPLE_COUNT = pvs_pkg::SAMPLE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pvs_pkg::in_item_t in_data,
  input  pvs_pkg::cmd_t     cmd,
  output pvs_pkg::sts_t     sts,
  pvs_out_if.source         out_ch,
  pvs_cfg_if.sink           cfg_ch
);
  import pvs_pkg::*;

  localparam int EFF_SLOTS = (SLOT_COUNT < REG_SLOTS) ? SLOT_COUNT : REG_SLOTS;
  localparam int N_RAW     = (SAMPLE_COUNT < CARRIED_SAMPLES) ? SAMPLE_COUNT
                                                             : CARRIED_SAMPLES;
  localparam int N_AVG     = (N_RAW < 1) ? 1 : N_RAW;
  localparam int RECIP     = ((2 ** RECIP_SH) + N_AVG - 1) / N_AVG;
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(EFF_SLOTS - 1);
  localparam logic [LVL_W-1:0]   CAP      = LVL_W'(WAIT_CAP);
  localparam logic [RECIP_W-1:0] RECIP_K  = RECIP_W'(RECIP);

  // config registers
  logic [MILLI_W-1:0] band_r;
  logic [CNT_W-1:0]   max_r;
  logic [SLOT_W-1:0]  slot_r [REG_SLOTS];

  // per-beat working registers
  logic [MINUTE_W-1:0] now_r;
  logic [SUM_W-1:0]    sum_r;
  logic [PROD_W-1:0]   prod_r;
  logic [MILLI_W-1:0]  avg_r;
  logic [IDX_W-1:0]    idx_r;
  logic                stop_r;
  logic                passed_r;
  logic                none_r;
  logic [IDX_W-1:0]    pass_idx_r;
  logic [MILLI_W-1:0]  sp_pass_r;
  logic [IDX_W-1:0]    last_idx_r;
  logic [MILLI_W-1:0]  sp_last_r;
  logic [IDX_W-1:0]    act_r;
  logic [ERR_W-1:0]    err_r;
  logic                neg_r;
  logic                in_band_r;
  logic [POS_W-1:0]    pos_r;

  // regulation state
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] drain_r, drain_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;

  out_item_t out_r, out_nxt;
  logic      out_valid_r;

  logic [SUM_W-1:0]    sum_in;
  logic [SLOT_W-1:0]   word;
  logic [MINUTE_W-1:0] t_cur;
  logic [ERR_W-1:0]    mag_full;
  logic [MILLI_W-1:0]  mag;
  logic [POS_W-1:0]    pos;
  logic [CNT_W-1:0]    fill_up, drain_up;
  logic [CNT_W:0]      step_sum;
  wait_t               kind;
  valve_t              action;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= MILLI_W'(100);
      max_r  <= CNT_W'(10);
      for (int i = 0; i < REG_SLOTS; i++) slot_r[i] <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        CFG_BAND:  band_r    <= cfg_ch.wdata[MILLI_W-1:0];
        CFG_MAX:   max_r     <= cfg_ch.wdata[CNT_W-1:0];
        CFG_SLOT0: slot_r[0] <= cfg_ch.wdata;
        CFG_SLOT1: slot_r[1] <= cfg_ch.wdata;
        CFG_SLOT2: slot_r[2] <= cfg_ch.wdata;
        CFG_SLOT3: slot_r[3] <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // sum of the samples that take part
  always_comb begin
    sum_in = SUM_W'(in_data.sample_first);
    if (N_AVG >= 2) sum_in = sum_in + SUM_W'(in_data.sample_second);
    if (N_AVG >= 3) sum_in = sum_in + SUM_W'(in_data.sample_third);
  end

  assign word  = slot_r[idx_r];
  assign t_cur = word[SLOT_W-1:MILLI_W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r <= in_data.minute_of_day;
      sum_r <= sum_in;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(sum_r) * PROD_W'(RECIP_K);
    end
    if (cmd.walk) begin
      avg_r <= prod_r[RECIP_SH +: MILLI_W];
      if (idx_r == '0) none_r <= (t_cur == '0);
      if (t_cur != '0) begin
        last_idx_r <= idx_r;
        sp_last_r  <= word[MILLI_W-1:0];
      end
      if (!stop_r) begin
        if (t_cur == '0 || now_r <= t_cur) begin
          stop_r <= 1'b1;
        end else begin
          passed_r   <= 1'b1;
          pass_idx_r <= idx_r;
          sp_pass_r  <= word[MILLI_W-1:0];
        end
      end
    end
    if (cmd.mul) begin
      stop_r     <= 1'b0;
      passed_r   <= 1'b0;
      last_idx_r <= '0;
      sp_last_r  <= '0;
    end
    if (cmd.err) begin
      act_r <= passed_r ? pass_idx_r : last_idx_r;
      err_r <= {1'b0, (passed_r ? sp_pass_r : sp_last_r)} - {1'b0, avg_r};
    end
    if (cmd.cmp) begin
      neg_r     <= err_r[ERR_W-1];
      in_band_r <= (mag <= band_r);
      pos_r     <= pos;
    end
  end

  // slot index counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.mul) begin
      idx_r <= '0;
    end else if (cmd.walk && idx_r != LAST_IDX) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  assign sts.walk_last = (idx_r == LAST_IDX);

  assign mag_full = err_r[ERR_W-1] ? (~err_r + 1'b1) : err_r;
  assign mag      = mag_full[MILLI_W-1:0];

  always_comb begin
    if (mag >= MILLI_W'(5 * PULSE_STEP))      pos = 3'd5;
    else if (mag >= MILLI_W'(4 * PULSE_STEP)) pos = 3'd4;
    else if (mag >= MILLI_W'(3 * PULSE_STEP)) pos = 3'd3;
    else if (mag >= MILLI_W'(2 * PULSE_STEP)) pos = 3'd2;
    else if (mag >= MILLI_W'(PULSE_STEP))     pos = 3'd1;
    else                                      pos = 3'd0;
  end

  // counters and wait level for this beat
  always_comb begin
    fill_up   = (fill_r  != '1) ? fill_r  + 1'b1 : fill_r;
    drain_up  = (drain_r != '1) ? drain_r + 1'b1 : drain_r;
    fill_nxt  = fill_r;
    drain_nxt = drain_r;
    action    = VALVE_NONE;
    step_sum  = '0;
    if (none_r) begin
      kind = WAIT_LONG;
    end else if (in_band_r) begin
      kind      = WAIT_PROG;
      fill_nxt  = '0;
      drain_nxt = '0;
    end else begin
      if (!neg_r) begin
        action   = VALVE_FILL;
        fill_nxt = fill_up;
      end else begin
        action    = VALVE_DRAIN;
        drain_nxt = drain_up;
      end
      step_sum = {1'b0, fill_nxt} + {1'b0, drain_nxt};
      if (step_sum > {1'b0, max_r}) begin
        kind      = WAIT_LONG;
        fill_nxt  = '0;
        drain_nxt = '0;
      end else begin
        kind = WAIT_NONE;
      end
    end

    case (kind)
      WAIT_NONE: lvl_nxt = LVL_W'(1);
      WAIT_PROG: lvl_nxt = (lvl_r < CAP) ? lvl_r + 1'b1 : CAP;
      default:   lvl_nxt = CAP;
    endcase

    out_nxt.valve_action  = action;
    out_nxt.pulse_ms      = (action == VALVE_NONE) ? '0 : pulse_of(pos_r);
    out_nxt.wait_kind     = kind;
    out_nxt.wait_units    = lvl_nxt;
    out_nxt.fill_steps    = fill_nxt;
    out_nxt.drain_steps   = drain_nxt;
    out_nxt.active_slot   = none_r ? '0 : act_r;
    out_nxt.no_slots      = none_r;
    out_nxt.average_milli = avg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      drain_r <= '0;
      lvl_r   <= LVL_W'(1);
    end else if (cmd.upd) begin
      fill_r  <= fill_nxt;
      drain_r <= drain_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

  // output register: holds a finished beat while the next one is worked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) out_r <= out_nxt;
  end

  assign sts.out_free = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_band_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd && !none_r && in_band_r |=> fill_r == '0 && drain_r == '0)
    else $error("settled beat left step counters set");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("slot index past the last slot in use");

  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r != '0 && lvl_r <= CAP)
    else $error("wait level out of range");

  a_out_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.upd))
    else $error("output valid without an update");

  a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd && none_r |=> out_r.valve_action == VALVE_NONE && out_r.pulse_ms == '0)
    else $error("pulse given with no slots set");

endmodule
